@@ design/rpsm_pkg.sv @@
// rpsm_pkg: shared types and constants for the remote page slot mapper
// used by the controller, the datapath and the top level
`default_nettype none
package rpsm_pkg;

  localparam int PAGES    = 1024;
  localparam int PAGE_W   = 10;
  localparam int STATUS_W = 2;
  localparam int OFFSET_W = 22;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNMAPPED = 2'd2;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_FREE_WR,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_RESP
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic accept;
    logic map_inval;
    logic free_rd;
    logic free_wr;
    logic srch_init;
    logic srch_rd;
    logic alloc;
    logic next_chunk;
    logic fallback;
    logic res_lookup;
    logic res_full;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic mode;
    logic map_valid;
    logic word_full;
    logic chunk_last;
    logic on_fallback;
  } dp_status_t;

endpackage
`default_nettype wire

@@ design/rpsm_ctrl.sv @@
// rpsm_ctrl: controller state machine for the remote page slot mapper
// depends on rpsm_pkg; drives the datapath through ctrl_cmd_t
`default_nettype none
module rpsm_ctrl import rpsm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  wire logic       out_stall,
  input  wire dp_status_t sts,
  output ctrl_cmd_t       cmd
);

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (sts.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_LOOKUP;
      end
      S_LOOKUP: begin
        if (sts.mode == MODE_READ) state_next = S_RESP;
        else if (sts.map_valid) state_next = S_FREE_WR;
        else state_next = S_SRCH_RD;
      end
      S_FREE_WR: state_next = S_SRCH_RD;
      S_SRCH_RD: state_next = S_SRCH_CHK;
      S_SRCH_CHK: begin
        if (!sts.word_full) state_next = S_RESP;
        else if (sts.chunk_last && sts.on_fallback) state_next = S_RESP;
        else state_next = S_SRCH_RD;
      end
      S_RESP: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      S_CLEAR: cmd.clr_step = 1'b1;
      S_IDLE: cmd.accept = in_valid;
      S_LOOKUP: begin
        if (sts.mode == MODE_READ) begin
          cmd.res_lookup = 1'b1;
        end else begin
          cmd.map_inval = 1'b1;
          cmd.free_rd   = sts.map_valid;
          cmd.srch_init = 1'b1;
        end
      end
      S_FREE_WR: cmd.free_wr = 1'b1;
      S_SRCH_RD: cmd.srch_rd = 1'b1;
      S_SRCH_CHK: begin
        if (!sts.word_full) begin
          cmd.alloc = 1'b1;
        end else if (!sts.chunk_last) begin
          cmd.next_chunk = 1'b1;
        end else if (!sts.on_fallback) begin
          cmd.fallback = 1'b1;
        end else begin
          cmd.res_full = 1'b1;
        end
      end
      S_RESP: cmd.out_load = out_free;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ design/rpsm_dpath.sv @@
// rpsm_dpath: page map and slot bitmap memories, search counters, result registers
// depends on rpsm_pkg; commanded by rpsm_ctrl
`default_nettype none
module rpsm_dpath import rpsm_pkg::*; #(
  parameter int SLOTS_PER_NODE   = 1024,
  parameter int CHUNK_SLOTS      = 64,
  parameter int PAGE_BYTES_SHIFT = 12
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ctrl_cmd_t           cmd,
  output dp_status_t               sts,
  input  wire logic                mode,
  input  wire logic [PAGE_W-1:0]   page_id,
  output logic [STATUS_W-1:0]      status,
  output logic                     node,
  output logic [OFFSET_W-1:0]      remote_offset
);

  localparam int CHUNKS = SLOTS_PER_NODE / CHUNK_SLOTS;
  localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int BW     = $clog2(CHUNK_SLOTS);
  localparam int IW     = CW + 1;
  localparam int BMD    = 2 << CW;
  localparam int CLRN   = (BMD > PAGES) ? BMD : PAGES;
  localparam int CLW    = $clog2(CLRN);
  localparam int SLOTW  = $clog2(CHUNKS * CHUNK_SLOTS) + 1;
  localparam int OWW    = SLOTW + PAGE_BYTES_SHIFT + OFFSET_W;

  typedef struct packed {
    logic          valid;
    logic          node;
    logic [CW-1:0] chunk;
    logic [BW-1:0] bit_idx;
  } map_entry_t;

  map_entry_t             map_mem [PAGES];
  logic [CHUNK_SLOTS-1:0] bm_mem  [BMD];

  map_entry_t             map_q, map_wdata;
  logic                   map_we;
  logic [PAGE_W-1:0]      map_waddr;
  logic [CHUNK_SLOTS-1:0] bm_q, bm_wdata;
  logic                   bm_we, bm_re;
  logic [IW-1:0]          bm_waddr, bm_raddr;

  logic [CLW-1:0]         clr;
  logic                   mode_r;
  logic [PAGE_W-1:0]      page_r;
  logic                   node_cur;
  logic [CW-1:0]          chunk_cur;
  logic                   fb;
  logic [BW-1:0]          zero_idx;
  logic [STATUS_W-1:0]    res_status;
  logic                   res_node;
  logic [CW-1:0]          res_chunk;
  logic [BW-1:0]          res_bit;
  logic [SLOTW-1:0]       slot;
  logic [OWW-1:0]         off_wide;

  always_comb begin
    zero_idx = '0;
    for (int i = CHUNK_SLOTS - 1; i >= 0; i--) begin
      if (!bm_q[i]) zero_idx = BW'(i);
    end
  end

  always_comb begin
    map_we    = 1'b0;
    map_waddr = page_r;
    map_wdata = '0;
    if (cmd.clr_step) begin
      map_we    = (32'(clr) < 32'(PAGES));
      map_waddr = clr[PAGE_W-1:0];
    end else if (cmd.map_inval) begin
      map_we = 1'b1;
    end else if (cmd.alloc) begin
      map_we    = 1'b1;
      map_wdata = '{valid: 1'b1, node: node_cur, chunk: chunk_cur, bit_idx: zero_idx};
    end
  end

  always_comb begin
    bm_we    = 1'b0;
    bm_waddr = {node_cur, chunk_cur};
    bm_wdata = bm_q | (bm_q + CHUNK_SLOTS'(1));
    if (cmd.clr_step) begin
      bm_we    = (32'(clr) < 32'(BMD));
      bm_waddr = clr[IW-1:0];
      bm_wdata = '0;
    end else if (cmd.free_wr) begin
      bm_we    = 1'b1;
      bm_waddr = {map_q.node, map_q.chunk};
      bm_wdata = bm_q & ~(CHUNK_SLOTS'(1) << map_q.bit_idx);
    end else if (cmd.alloc) begin
      bm_we = 1'b1;
    end
  end

  assign bm_re    = cmd.free_rd || cmd.srch_rd;
  assign bm_raddr = cmd.free_rd ? {map_q.node, map_q.chunk} : {node_cur, chunk_cur};

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    if (cmd.accept) map_q <= map_mem[page_id];
    if (bm_we) bm_mem[bm_waddr] <= bm_wdata;
    if (bm_re) bm_q <= bm_mem[bm_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (cmd.clr_step) begin
      clr <= clr + CLW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r <= mode;
      page_r <= page_id;
    end
    if (cmd.srch_init) begin
      node_cur  <= page_r[0];
      chunk_cur <= '0;
      fb        <= 1'b0;
    end else if (cmd.fallback) begin
      node_cur  <= ~node_cur;
      chunk_cur <= '0;
      fb        <= 1'b1;
    end else if (cmd.next_chunk) begin
      chunk_cur <= chunk_cur + CW'(1);
    end
    if (cmd.res_lookup) begin
      res_status <= map_q.valid ? ST_OK : ST_UNMAPPED;
      res_node   <= map_q.valid & map_q.node;
      res_chunk  <= map_q.valid ? map_q.chunk : '0;
      res_bit    <= map_q.valid ? map_q.bit_idx : '0;
    end else if (cmd.alloc) begin
      res_status <= ST_OK;
      res_node   <= node_cur;
      res_chunk  <= chunk_cur;
      res_bit    <= zero_idx;
    end else if (cmd.res_full) begin
      res_status <= ST_FULL;
      res_node   <= 1'b0;
      res_chunk  <= '0;
      res_bit    <= '0;
    end
  end

  assign slot     = SLOTW'(res_chunk) * SLOTW'(CHUNK_SLOTS) + SLOTW'(res_bit);
  assign off_wide = OWW'(slot) << PAGE_BYTES_SHIFT;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status        <= res_status;
      node          <= res_node;
      remote_offset <= off_wide[OFFSET_W-1:0];
    end
  end

  assign sts.clr_done    = (clr == CLW'(CLRN - 1));
  assign sts.mode        = mode_r;
  assign sts.map_valid   = map_q.valid;
  assign sts.word_full   = &bm_q;
  assign sts.chunk_last  = (chunk_cur == CW'(CHUNKS - 1));
  assign sts.on_fallback = fb;

endmodule
`default_nettype wire

@@ design/remote_page_slot_mapper_core.sv @@
// remote_page_slot_mapper_core: top level of the remote page slot mapper
// depends on rpsm_pkg, rpsm_ctrl and rpsm_dpath
// reads do lookup, response; writes add freeing any old slot, a read and check per chunk
// throughput: one item at a time, set by the one-port bitmap read and check loop
// reset: a clearing pass over the page map and slot bitmaps holds in_stall high
`default_nettype none
module remote_page_slot_mapper_core import rpsm_pkg::*; #(
  parameter int SLOTS_PER_NODE   = 1024,
  parameter int CHUNK_SLOTS      = 64,
  parameter int PAGE_BYTES_SHIFT = 12
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                mode,
  input  wire logic [PAGE_W-1:0]   page_id,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [STATUS_W-1:0]      status,
  output logic                     node,
  output logic [OFFSET_W-1:0]      remote_offset
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  rpsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rpsm_dpath #(
    .SLOTS_PER_NODE   (SLOTS_PER_NODE),
    .CHUNK_SLOTS      (CHUNK_SLOTS),
    .PAGE_BYTES_SHIFT (PAGE_BYTES_SHIFT)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .mode          (mode),
    .page_id       (page_id),
    .status        (status),
    .node          (node),
    .remote_offset (remote_offset)
  );

  a_clear_after_reset: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input taken during clearing pass");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item taken while busy");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_FULL || status == ST_UNMAPPED))
    else $error("bad status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (node == 1'b0 && remote_offset == '0))
    else $error("failed item carries a mapping");

endmodule
`default_nettype wire

@@ sim/rpsm_checker.sv @@
// rpsm_checker: watches both channels of the remote page slot mapper, predicts each result
// from its own copy of the page map and slot bitmaps, and compares; depends on rpsm_pkg
`default_nettype none
module rpsm_checker import rpsm_pkg::*; #(
  parameter int SLOTS_PER_NODE   = 1024,
  parameter int CHUNK_SLOTS      = 64,
  parameter int PAGE_BYTES_SHIFT = 12
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                in_stall,
  input  wire logic                mode,
  input  wire logic [PAGE_W-1:0]   page_id,
  input  wire logic                out_valid,
  input  wire logic                out_stall,
  input  wire logic [STATUS_W-1:0] status,
  input  wire logic                node,
  input  wire logic [OFFSET_W-1:0] remote_offset,
  output int                       fail_count,
  output int                       pending
);
  localparam int CHUNKS = SLOTS_PER_NODE / CHUNK_SLOTS;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic                node;
    logic [OFFSET_W-1:0] offset;
  } mapping_t;

  logic                   page_mapped [PAGES];
  logic                   page_node   [PAGES];
  int                     page_slot   [PAGES];
  logic [CHUNK_SLOTS-1:0] use_bits    [2*CHUNKS];
  int                     free_slots  [2*CHUNKS];
  mapping_t               mapping_q[$];

  task automatic report(input string what, input int got, input int want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    fail_count++;
  endtask

  function automatic void clear_map();
    for (int i = 0; i < PAGES; i++) page_mapped[i] = 1'b0;
    for (int i = 0; i < 2*CHUNKS; i++) begin
      use_bits[i] = '0;
      free_slots[i] = CHUNK_SLOTS;
    end
  endfunction

  function automatic bit grab_slot(input int nd, output int slot);
    int idx;
    slot = 0;
    for (int c = 0; c < CHUNKS; c++) begin
      idx = nd * CHUNKS + c;
      if (free_slots[idx] != 0) begin
        for (int b = 0; b < CHUNK_SLOTS; b++) begin
          if (!use_bits[idx][b]) begin
            use_bits[idx][b] = 1'b1;
            free_slots[idx]--;
            slot = c * CHUNK_SLOTS + b;
            return 1;
          end
        end
      end
    end
    return 0;
  endfunction

  function automatic mapping_t predict_mapping(input logic md, input int pg);
    mapping_t r;
    int idx, slot, pref;
    logic [63:0] wide;
    r.status = ST_OK;
    r.node = 1'b0;
    r.offset = '0;
    if (md == MODE_READ) begin
      if (!page_mapped[pg]) begin
        r.status = ST_UNMAPPED;
        return r;
      end
    end else begin
      if (page_mapped[pg]) begin
        idx = page_node[pg] * CHUNKS + page_slot[pg] / CHUNK_SLOTS;
        if (use_bits[idx][page_slot[pg] % CHUNK_SLOTS]) begin
          use_bits[idx][page_slot[pg] % CHUNK_SLOTS] = 1'b0;
          if (free_slots[idx] < CHUNK_SLOTS) free_slots[idx]++;
        end
        page_mapped[pg] = 1'b0;
      end
      pref = pg & 1;
      if (grab_slot(pref, slot)) begin
        page_node[pg] = pref[0];
      end else if (grab_slot(pref ^ 1, slot)) begin
        page_node[pg] = ~pref[0];
      end else begin
        r.status = ST_FULL;
        return r;
      end
      page_mapped[pg] = 1'b1;
      page_slot[pg] = slot;
    end
    r.node = page_node[pg];
    wide = 64'(page_slot[pg]) << PAGE_BYTES_SHIFT;
    r.offset = wide[OFFSET_W-1:0];
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
    clear_map();
  end

  always @(posedge clk) begin
    mapping_t want;
    if (rst) begin
      clear_map();
    end else begin
      if (in_valid && !in_stall) mapping_q.push_back(predict_mapping(mode, int'(page_id)));
      if (out_valid && !out_stall) begin
        if (mapping_q.size() == 0) begin
          report("unexpected item", 1, 0);
        end else begin
          want = mapping_q.pop_front();
          if (status !== want.status) report("status", int'(status), int'(want.status));
          if (node !== want.node) report("node", int'(node), int'(want.node));
          if (remote_offset !== want.offset)
            report("remote_offset", int'(remote_offset), int'(want.offset));
        end
      end
    end
    pending = mapping_q.size();
  end
endmodule
`default_nettype wire

@@ sim/remote_page_slot_mapper_core_tb.sv @@
// remote_page_slot_mapper_core_tb: drives writes and reads of page mappings with random
// gaps and stalls; depends on rpsm_pkg, the core and rpsm_checker
`default_nettype none
module remote_page_slot_mapper_core_tb import rpsm_pkg::*;;
  logic                clk, rst, in_valid, in_stall, mode, out_valid, out_stall, node;
  logic [PAGE_W-1:0]   page_id;
  logic [STATUS_W-1:0] status;
  logic [OFFSET_W-1:0] remote_offset;
  int fail_count, pending, writes_sent, reads_sent, results_seen;

  remote_page_slot_mapper_core dut (.*);

  rpsm_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int draw_wait();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
  endfunction

  task automatic send_item(input logic md, input logic [PAGE_W-1:0] pg);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= md;
    page_id <= pg;
    if (md == MODE_WRITE) writes_sent++;
    else reads_sent++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver with one long hold-off so the core backs up
  initial begin
    int n;
    out_stall = 1'b1;
    results_seen = 0;
    forever begin
      n = (results_seen == 200) ? 400 : draw_wait();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      results_seen++;
      @(negedge clk);
    end
  end

  initial begin
    logic [PAGE_W-1:0] pg;
    int guard;
    rst = 1'b1;
    in_valid = 1'b0;
    mode = MODE_WRITE;
    page_id = '0;
    writes_sent = 0;
    reads_sent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed: unmapped reads, field extremes, rewrite of a mapped page
    send_item(MODE_READ, 10'd0);
    send_item(MODE_READ, 10'd1023);
    send_item(MODE_WRITE, 10'd0);
    send_item(MODE_WRITE, 10'd1);
    send_item(MODE_WRITE, 10'd1022);
    send_item(MODE_WRITE, 10'd1023);
    send_item(MODE_READ, 10'd0);
    send_item(MODE_READ, 10'd1023);
    send_item(MODE_WRITE, 10'd0);
    send_item(MODE_READ, 10'd0);
    send_item(MODE_WRITE, 10'd0);
    send_item(MODE_WRITE, 10'd512);
    send_item(MODE_READ, 10'd513);
    send_item(MODE_READ, 10'd1);
    send_item(MODE_WRITE, 10'd1023);
    send_item(MODE_READ, 10'd1023);
    for (int i = 0; i < 1000; i++) begin
      pg = ($urandom_range(0, 2) == 0) ? 10'($urandom_range(0, 15)) : 10'($urandom);
      send_item(($urandom_range(0, 1) == 0) ? MODE_WRITE : MODE_READ, pg);
    end
    in_valid <= 1'b0;
    guard = 0;
    while (pending != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (60) @(posedge clk);
    $display("covered %0d writes and %0d reads, %0d results checked", writes_sent,
             reads_sent, results_seen);
    $display("including a long output hold-off that backed up the input");
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire
